### design/fsa_pkg.sv
// package for the frame/stamp association block
// shared types, opcodes, controller states and command/status structs; no dependencies
`default_nettype none
package fsa_pkg;
	localparam logic OP_HEADER = 1'b0;
	localparam logic OP_FRAME  = 1'b1;

	localparam int unsigned REG_RUNNING  = 0;
	localparam int unsigned REG_THROTTLE = 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_FRAME_RD,
		ST_FRAME_WAIT,
		ST_HDR_RD,
		ST_HDR_WAIT,
		ST_MOD,
		ST_DROP,
		ST_OUT
	} fsa_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load_item;
		logic write_item;
		logic clear_search;
		logic rd_frame;
		logic rd_header;
		logic next_header;
		logic next_frame;
		logic take_match;
		logic mod_step;
		logic do_drop;
		logic load_out;
	} fsa_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic running;
		logic frames_left;
		logic headers_left;
		logic seq_equal;
		logic mod_busy;
		logic mod_needed;
	} fsa_status_t;
endpackage
`default_nettype wire

### design/fsa_ctrl.sv
// controller state machine for the frame/stamp association block
// depends on fsa_pkg
`default_nettype none
module fsa_ctrl
	import fsa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_req,
	output logic             in_rdy,
	input  wire logic        out_busy,
	input  wire fsa_status_t status,
	output fsa_cmd_t         cmd
);
	fsa_state_t state_q, state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_req) state_next = ST_WRITE;
			end
			ST_WRITE: begin
				if (status.running) state_next = ST_FRAME_RD;
				else state_next = ST_DROP;
			end
			ST_FRAME_RD: begin
				if (status.frames_left) state_next = ST_FRAME_WAIT;
				else state_next = ST_DROP;
			end
			ST_FRAME_WAIT: state_next = ST_HDR_RD;
			ST_HDR_RD: begin
				if (status.headers_left) state_next = ST_HDR_WAIT;
				else state_next = ST_FRAME_RD;
			end
			ST_HDR_WAIT: begin
				if (status.seq_equal) begin
					if (status.mod_needed) state_next = ST_MOD;
					else state_next = ST_DROP;
				end else begin
					state_next = ST_HDR_RD;
				end
			end
			ST_MOD: begin
				if (!status.mod_busy) state_next = ST_DROP;
			end
			ST_DROP: state_next = ST_OUT;
			ST_OUT: begin
				if (!out_busy) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_rdy = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_rdy = 1'b1;
				cmd.load_item = in_req;
			end
			ST_WRITE: begin
				cmd.write_item = 1'b1;
				cmd.clear_search = 1'b1;
			end
			ST_FRAME_RD: cmd.rd_frame = status.frames_left;
			ST_FRAME_WAIT: ;
			ST_HDR_RD: begin
				cmd.rd_header = status.headers_left;
				cmd.next_frame = !status.headers_left;
			end
			ST_HDR_WAIT: begin
				cmd.take_match = status.seq_equal;
				cmd.next_header = !status.seq_equal;
			end
			ST_MOD: cmd.mod_step = 1'b1;
			ST_DROP: cmd.do_drop = 1'b1;
			ST_OUT: cmd.load_out = !out_busy;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

### design/fsa_datapath.sv
// datapath of the frame/stamp association block: ring memories, search
// indexes, throttle modulo unit and result register; depends on fsa_pkg
`default_nettype none
module fsa_datapath
	import fsa_pkg::*;
#(
	parameter int unsigned BUFFER_DEPTH = 128
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [0:0]   cfg_index,
	input  wire logic [15:0]  cfg_data,
	input  wire logic         in_opcode,
	input  wire logic [31:0]  in_seq,
	input  wire logic [63:0]  in_stamp,
	input  wire logic [31:0]  in_handle,
	input  wire fsa_cmd_t     cmd,
	output fsa_status_t       status,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [130:0]      out_data
);
	localparam int unsigned SLOTS = BUFFER_DEPTH + 1;
	localparam int unsigned AW = $clog2(SLOTS);
	localparam int unsigned CW = $clog2(SLOTS + 1);

	logic running_q;
	logic [15:0] divisor_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			divisor_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == 1'(REG_RUNNING)) running_q <= cfg_data[0];
			else divisor_q <= cfg_data;
		end
	end

	// item holding register
	logic        op_q;
	logic [31:0] seq_q, handle_q;
	logic [63:0] stamp_q;
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q <= in_opcode;
			seq_q <= in_seq;
			stamp_q <= in_stamp;
			handle_q <= in_handle;
		end
	end

	// ring addressing helper
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
		logic [AW+1:0] s;
		s = {2'b0, a} + {{(AW+2-CW){1'b0}}, b};
		if (s >= (AW+2)'(SLOTS)) s = s - (AW+2)'(SLOTS);
		return s[AW-1:0];
	endfunction

	logic [AW-1:0] f_head_q, h_head_q;
	logic [CW-1:0] f_cnt_q, h_cnt_q;
	logic [CW-1:0] fi_q, hi_q;

	// memories
	logic [63:0] f_mem [SLOTS];
	logic [95:0] h_mem [SLOTS];
	logic [63:0] f_rd_q;
	logic [95:0] h_rd_q;
	logic [AW-1:0] f_wa, h_wa;
	assign f_wa = wrap_add(f_head_q, f_cnt_q);
	assign h_wa = wrap_add(h_head_q, h_cnt_q);

	always_ff @(posedge clk) begin
		if (cmd.write_item && op_q == OP_FRAME && f_cnt_q < CW'(SLOTS))
			f_mem[f_wa] <= {handle_q, seq_q};
		if (cmd.rd_frame) f_rd_q <= f_mem[wrap_add(f_head_q, fi_q)];
	end
	always_ff @(posedge clk) begin
		if (cmd.write_item && op_q == OP_HEADER && h_cnt_q < CW'(SLOTS))
			h_mem[h_wa] <= {stamp_q, seq_q};
		if (cmd.rd_header) h_rd_q <= h_mem[wrap_add(h_head_q, hi_q)];
	end

	// match result registers
	logic        found_q, pass_q, drop_q;
	logic [31:0] m_handle_q, m_seq_q;
	logic [63:0] m_stamp_q;
	logic [31:0] tcount_q;

	// modulo unit: restoring division, one bit per cycle
	logic [31:0] rem_q, quo_src_q;
	logic [5:0]  mod_cnt_q;
	logic [32:0] rem_shift;
	assign rem_shift = {rem_q, quo_src_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_head_q <= '0;
			h_head_q <= '0;
			f_cnt_q <= '0;
			h_cnt_q <= '0;
			tcount_q <= '0;
			found_q <= 1'b0;
			mod_cnt_q <= '0;
		end else begin
			if (cmd.write_item) begin
				if (op_q == OP_FRAME && f_cnt_q < CW'(SLOTS)) f_cnt_q <= f_cnt_q + 1'b1;
				if (op_q == OP_HEADER && h_cnt_q < CW'(SLOTS)) h_cnt_q <= h_cnt_q + 1'b1;
				found_q <= 1'b0;
				mod_cnt_q <= 6'd32;
			end
			if (cmd.take_match) begin
				found_q <= 1'b1;
				f_head_q <= wrap_add(f_head_q, fi_q + 1'b1);
				f_cnt_q <= f_cnt_q - fi_q - 1'b1;
				h_head_q <= wrap_add(h_head_q, hi_q + 1'b1);
				h_cnt_q <= h_cnt_q - hi_q - 1'b1;
				if (divisor_q != '0) tcount_q <= tcount_q + 1'b1;
			end
			if (cmd.mod_step && mod_cnt_q != '0) mod_cnt_q <= mod_cnt_q - 1'b1;
			if (cmd.do_drop) begin
				if (op_q == OP_FRAME && f_cnt_q > CW'(BUFFER_DEPTH)) begin
					f_head_q <= wrap_add(f_head_q, CW'(1));
					f_cnt_q <= f_cnt_q - 1'b1;
				end
				if (op_q == OP_HEADER && h_cnt_q > CW'(BUFFER_DEPTH)) begin
					h_head_q <= wrap_add(h_head_q, CW'(1));
					h_cnt_q <= h_cnt_q - 1'b1;
				end
			end
		end
	end

	// search indexes, match capture, modulo datapath
	always_ff @(posedge clk) begin
		if (cmd.clear_search) begin
			fi_q <= '0;
			hi_q <= '0;
		end
		if (cmd.next_frame) begin
			fi_q <= fi_q + 1'b1;
			hi_q <= '0;
		end
		if (cmd.next_header) hi_q <= hi_q + 1'b1;
		if (cmd.write_item) begin
			pass_q <= 1'b0;
			m_handle_q <= '0;
			m_stamp_q <= '0;
			m_seq_q <= '0;
		end
		if (cmd.take_match) begin
			m_handle_q <= f_rd_q[63:32];
			m_stamp_q <= h_rd_q[95:32];
			m_seq_q <= h_rd_q[31:0];
			rem_q <= '0;
			quo_src_q <= tcount_q;
		end
		if (cmd.mod_step && mod_cnt_q != '0) begin
			if (rem_shift >= {17'b0, divisor_q}) rem_q <= 32'(rem_shift - {17'b0, divisor_q});
			else rem_q <= rem_shift[31:0];
			quo_src_q <= {quo_src_q[30:0], 1'b0};
		end
		if (cmd.do_drop) begin
			if (found_q && divisor_q != '0) pass_q <= rem_q != '0;
			drop_q <= (op_q == OP_FRAME) ? (f_cnt_q > CW'(BUFFER_DEPTH))
				: (h_cnt_q > CW'(BUFFER_DEPTH));
		end
	end

	assign status.running = running_q;
	assign status.frames_left = fi_q < f_cnt_q;
	assign status.headers_left = hi_q < h_cnt_q;
	assign status.seq_equal = f_rd_q[31:0] == h_rd_q[31:0];
	assign status.mod_busy = mod_cnt_q != '0;
	assign status.mod_needed = divisor_q != '0;

	// output register, held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.load_out)
			out_data <= {drop_q, pass_q, m_seq_q, m_stamp_q, m_handle_q, found_q};
	end
endmodule
`default_nettype wire

### design/frame_stamp_association_unit.sv
// Frame/stamp association unit. Pairs camera frames with trigger headers held in two
// oldest-first ring memories of BUFFER_DEPTH+1 slots and emits one result per request.
// A request is written to its ring without a search while stopped. While running, the
// search walks each held frame against every held header; a match stops the search at
// the matched pair and runs the modulo unit for the throttle remainder when the divisor
// is nonzero; an output stall holds the unit until the result is taken. The search walks
// at most frame count times header count pairs.
// Depends on fsa_pkg, fsa_ctrl, fsa_datapath.
`default_nettype none
module frame_stamp_association_unit
	import fsa_pkg::*;
#(
	parameter int unsigned BUFFER_DEPTH = 128
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [0:0]   cfg_index,
	input  wire logic [15:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// seq_number[31:0], time_stamp[95:32], frame_handle[127:96]
	input  wire logic [127:0] s_tdata,
	// opcode
	input  wire logic         s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// matched, out_handle, out_stamp, out_seq, throttle_pass, dropped_oldest; pad to 136
	output logic [135:0]      m_tdata
);
	fsa_cmd_t cmd;
	fsa_status_t status;
	logic [130:0] out_data;

	fsa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_req(s_tvalid), .in_rdy(s_tready),
		.out_busy(m_tvalid && !m_tready), .status(status), .cmd(cmd)
	);

	fsa_datapath #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_opcode(s_tuser), .in_seq(s_tdata[31:0]),
		.in_stamp(s_tdata[95:32]), .in_handle(s_tdata[127:96]), .cmd(cmd),
		.status(status), .out_valid(m_tvalid), .out_ready(m_tready), .out_data(out_data)
	);

	assign m_tdata = {5'b0, out_data};
endmodule
`default_nettype wire
